@@ hw/rtl/crc32srf_pkg.sv @@
// Package for the CRC-32 set-request framer: transaction types, constants
// and the byte-wide reflected CRC-32 update. No dependencies.
package crc32srf_pkg;

    localparam int MAX_DATA_LEN_DEF = 64;
    localparam int RES_MAX          = 5;   // most results one item can cause

    localparam logic [7:0]  HEADER_BYTE = 8'h53;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] SEED_RESET  = 32'h2060_EFC3;

    localparam logic       CMD_START = 1'b0;
    localparam logic       CMD_DATA  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_LONG  = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rpt_id;
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_packet;
        logic [1:0] status;
    } res_t;

    // Reflected CRC-32, one byte folded in, LSB first
    function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/crc32_set_request_framer_core.sv @@
// CRC-32 set-request framer, top level.
// The first result of an item is on res in the cycle after its acceptance.
// An item causing n results (up to 5) holds the item port until all its results but the last have left
//   the single-byte result port; items causing zero or one result flow at one a cycle while res_ready is high.
// Reset (rst_n, async, active low): seed to its reset value, CRC to all ones,
//   byte count and tail delay to zero, result buffer empty.
// Depends on crc32srf_pkg.
module crc32_set_request_framer_core #(
    parameter int MAX_DATA_LEN = crc32srf_pkg::MAX_DATA_LEN_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  crc32srf_pkg::item_t  item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output crc32srf_pkg::res_t   res,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata
);

    // Count saturates at MAX_DATA_LEN + 1, so it needs room for that value
    localparam int CNT_W = $clog2(MAX_DATA_LEN + 2);
    localparam int RN    = crc32srf_pkg::RES_MAX;
    localparam int RN_W  = $clog2(RN + 1);

    localparam logic [CNT_W-1:0] CNT_FOUR = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_DATA_LEN);

    logic [31:0]      seed_reg;
    logic [31:0]      crc_reg,   crc_next;
    logic [7:0]       tail_reg   [4];
    logic [7:0]       tail_next  [4];
    logic [CNT_W-1:0] count_reg, count_next;

    // Result buffer: entry 0 is what res shows; it shifts down on each pop unless a new item loads it
    crc32srf_pkg::res_t res_buf_reg [RN];
    crc32srf_pkg::res_t res_buf_next[RN];
    logic [RN_W-1:0]    res_cnt_reg, res_cnt_next;

    logic load, pop;

    // Item is taken when the buffer is empty or its final entry leaves this cycle
    assign res_valid  = (res_cnt_reg != '0);
    assign res        = res_buf_reg[0];
    assign pop        = res_valid && res_ready;
    assign item_ready = (res_cnt_reg == '0) || ((res_cnt_reg == RN_W'(1)) && res_ready);
    assign load       = item_valid && item_ready;

    // Per-item framing logic: one byte fold, tail shift and result assembly
    logic [31:0]        crc_fold;
    logic [31:0]        crc_out;
    logic               emit;
    logic [CNT_W-1:0]   count_inc;
    crc32srf_pkg::res_t tail_res[4];
    logic [RN_W-1:0]    n_res;

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        tail_next  = tail_reg;
        crc_fold   = crc_reg;
        crc_out    = ~crc_reg;
        emit       = 1'b0;
        count_inc  = count_reg;
        n_res      = '0;
        for (int k = 0; k < 4; k++)
        begin
            tail_res[k] = '{out_byte: 8'd0, end_of_packet: 1'b0,
                            status: crc32srf_pkg::STATUS_OK};
        end
        for (int k = 0; k < RN; k++)
        begin
            res_buf_next[k] = '{out_byte: 8'd0, end_of_packet: 1'b0,
                                status: crc32srf_pkg::STATUS_OK};
        end

        if (item.cmd == crc32srf_pkg::CMD_START)
        begin
            // Header then report id; a fresh CRC seeded from the inverse of the seed
            crc_next   = crc32srf_pkg::fold_byte(~seed_reg, item.rpt_id);
            count_next = '0;
            for (int k = 0; k < 4; k++)
            begin
                tail_next[k] = 8'd0;
            end
            res_buf_next[0].out_byte = crc32srf_pkg::HEADER_BYTE;
            res_buf_next[1].out_byte = item.rpt_id;
            n_res = RN_W'(2);
        end
        else
        begin
            // Oldest tail byte leaves once four are held
            emit     = (count_reg >= CNT_FOUR);
            crc_fold = emit ? crc32srf_pkg::fold_byte(crc_reg, tail_reg[0]) : crc_reg;
            crc_out  = ~crc_fold;
            tail_next[0] = tail_reg[1];
            tail_next[1] = tail_reg[2];
            tail_next[2] = tail_reg[3];
            tail_next[3] = item.data_byte;
            count_inc  = (count_reg <= CNT_MAX) ? count_reg + CNT_W'(1) : count_reg;
            crc_next   = crc_fold;
            count_next = count_inc;

            if (item.last)
            begin
                if (count_inc < CNT_FOUR)
                begin
                    tail_res[0] = '{out_byte: 8'd0, end_of_packet: 1'b1,
                                    status: crc32srf_pkg::STATUS_SHORT};
                    n_res = RN_W'(1);
                end
                else if (count_inc > CNT_MAX)
                begin
                    tail_res[0] = '{out_byte: 8'd0, end_of_packet: 1'b1,
                                    status: crc32srf_pkg::STATUS_LONG};
                    n_res = RN_W'(1);
                end
                else
                begin
                    // Inverted CRC, little-endian; the held tail bytes are dropped
                    tail_res[0].out_byte = crc_out[7:0];
                    tail_res[1].out_byte = crc_out[15:8];
                    tail_res[2].out_byte = crc_out[23:16];
                    tail_res[3].out_byte = crc_out[31:24];
                    tail_res[3].end_of_packet = 1'b1;
                    n_res = RN_W'(4);
                end
                crc_next   = '1;
                count_next = '0;
                for (int k = 0; k < 4; k++)
                begin
                    tail_next[k] = 8'd0;
                end
            end

            if (emit)
            begin
                res_buf_next[0].out_byte = tail_reg[0];
                for (int k = 0; k < 4; k++)
                begin
                    res_buf_next[k+1] = tail_res[k];
                end
                n_res = n_res + RN_W'(1);
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    res_buf_next[k] = tail_res[k];
                end
            end
        end

        if (load)
        begin
            res_cnt_next = n_res;
        end
        else if (pop)
        begin
            res_cnt_next = res_cnt_reg - RN_W'(1);
        end
        else
        begin
            res_cnt_next = res_cnt_reg;
        end
    end

    // Control and framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= crc32srf_pkg::SEED_RESET;
            crc_reg     <= '1;
            count_reg   <= '0;
            res_cnt_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                tail_reg[k] <= 8'd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            if (load)
            begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
                tail_reg  <= tail_next;
            end
            res_cnt_reg <= res_cnt_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_buf_reg <= res_buf_next;
        end
        else if (pop)
        begin
            for (int k = 0; k < RN - 1; k++)
            begin
                res_buf_reg[k] <= res_buf_reg[k+1];
            end
        end
    end

endmodule
